/* rtl/tsbq_pkg.sv */
package tsbq_pkg;

  // default configuration of the cascade
  localparam int SECTIONS_DEF    = 3;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COEF_BITS_DEF   = 20;
  localparam int STATE_BITS_DEF  = 40;

  // signal format between sections and at the output
  localparam int SIG_BITS = 22;
  localparam int SIG_FRAC = 4;

  localparam logic [SIG_BITS-1:0] SIG_MAX = {1'b0, {(SIG_BITS-1){1'b1}}};
  localparam logic [SIG_BITS-1:0] SIG_MIN = {1'b1, {(SIG_BITS-1){1'b0}}};

  // width of the register index on the configuration port
  localparam int CFG_IDX_BITS = 8;

  // one sample handed from a cell to its neighbour
  typedef struct packed {
    logic                       valid;
    logic signed [SIG_BITS-1:0] y;
  } tsbq_link_t;

endpackage

/* rtl/three_section_biquad_cascade.sv */
// Cascade of SECTIONS second-order IIR sections (DF2T), one cell per section, each with
// its own multiplier and its two delay values. Each cell produces its output after its
// multiply steps, and the next cell starts as soon as that output is ready; the last cell
// then updates its delay values. A new item is taken only when every cell is idle and the
// last result has moved into the output register, so one sample is in flight at a time.
// A clear command produces no result. Registers 2s and 2s+1 hold b0,b1,b2 and a1,a2 of
// section s, packed low slot first; writes to other indexes are ignored. The output
// register lets the next sample enter while a result still waits to be taken.
module three_section_biquad_cascade import tsbq_pkg::*; #(
  parameter int SECTIONS    = SECTIONS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SIG_BITS-1:0] filtered_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [3*COEF_BITS-1:0]     cfg_data_i
);

  localparam int RAW_W = SAMPLE_BITS + SIG_FRAC;
  localparam int EXT_W = (RAW_W > SIG_BITS) ? RAW_W : SIG_BITS;

  tsbq_link_t            link [SECTIONS+1];
  logic [SECTIONS-1:0]   busy;
  logic [SECTIONS-1:0]   link_valid;
  logic                  in_xfer, filt_xfer, clr_xfer;
  logic [EXT_W-1:0]      x_ext;
  logic [SIG_BITS-1:0]   x_in;
  logic                  run_q, res_pend_q, out_valid_q;
  logic signed [SIG_BITS-1:0] out_q;
  logic                  load;

  // input transfer, decoded by command
  assign in_stall_o = run_q || (|busy);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign filt_xfer  = in_xfer && !command_i;
  assign clr_xfer   = in_xfer && command_i;

  // raw sample into the signal format, saturated
  assign x_ext = EXT_W'(sample_i) << SIG_FRAC;
  assign x_in  = (x_ext > EXT_W'(SIG_MAX)) ? SIG_MAX : x_ext[SIG_BITS-1:0];

  assign link[0].valid = filt_xfer;
  assign link[0].y     = x_in;

  // configuration is always accepted
  assign cfg_ready_o = 1'b1;

  // row of section cells
  for (genvar s = 0; s < SECTIONS; s++) begin : g_cell
    tsbq_cell #(
      .COEF_BITS  (COEF_BITS),
      .STATE_BITS (STATE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .num_we_i   (cfg_valid_i && cfg_index_i == CFG_IDX_BITS'(2*s)),
      .den_we_i   (cfg_valid_i && cfg_index_i == CFG_IDX_BITS'(2*s+1)),
      .cfg_data_i (cfg_data_i),
      .clear_i    (clr_xfer),
      .link_i     (link[s]),
      .link_o     (link[s+1]),
      .busy_o     (busy[s])
    );
    assign link_valid[s] = link[s+1].valid;
  end

  // result hand-over into the output register
  assign load = res_pend_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (filt_xfer) begin
        run_q <= 1'b1;
      end else if (load) begin
        run_q <= 1'b0;
      end
      if (link[SECTIONS].valid) begin
        res_pend_q <= 1'b1;
      end else if (load) begin
        res_pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= link[SECTIONS].y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_q;

  // a filter sample starts the first cell
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filt_xfer |=> busy[0])
    else $error("first cell not started by a filter sample");

  // a clear command leaves nothing in flight
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_xfer |=> (!run_q && !res_pend_q))
    else $error("clear command produced work");

  // a pending result always belongs to a running item
  a_pend_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_pend_q |-> run_q)
    else $error("result pending without an item in flight");

  // only one section output travels along the row at a time
  a_one_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(link_valid))
    else $error("more than one section output at once");

endmodule

/* rtl/tsbq_cell.sv */
module tsbq_cell import tsbq_pkg::*; #(
  parameter int COEF_BITS  = COEF_BITS_DEF,
  parameter int STATE_BITS = STATE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   num_we_i,
  input  logic                   den_we_i,
  input  logic [3*COEF_BITS-1:0] cfg_data_i,
  input  logic                   clear_i,
  input  tsbq_link_t             link_i,
  output tsbq_link_t             link_o,
  output logic                   busy_o
);

  localparam int COEF_FRAC = COEF_BITS - 2;
  localparam int PROD_W    = SIG_BITS + COEF_BITS;
  localparam int ACC_W     = ((PROD_W > STATE_BITS) ? PROD_W : STATE_BITS) + 2;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic [STATE_BITS-1:0] Z_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic [STATE_BITS-1:0] Z_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MB0,
    ST_ACC,
    ST_YOUT,
    ST_A1,
    ST_Z1,
    ST_A2,
    ST_Z2
  } cell_state_e;

  cell_state_e state_q;

  logic [3*COEF_BITS-1:0] num_q;
  logic [2*COEF_BITS-1:0] den_q;

  logic signed [STATE_BITS-1:0] z1_q, z2_q;
  logic signed [SIG_BITS-1:0]   x_q, y_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q, sum_q;

  logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2;
  logic signed [COEF_BITS-1:0] coef_op;
  logic signed [SIG_BITS-1:0]  sig_op;
  logic signed [PROD_W-1:0]    mul_res;

  logic signed [ACC_W-1:0]      acc_d, y_sh, z_diff;
  logic [ACC_W-SIG_BITS:0]      y_hi;
  logic [ACC_W-STATE_BITS:0]    z_hi;
  logic signed [SIG_BITS-1:0]   y_d;
  logic signed [STATE_BITS-1:0] z_d;

  // unpack coefficients
  assign b0 = num_q[COEF_BITS-1:0];
  assign b1 = num_q[2*COEF_BITS-1:COEF_BITS];
  assign b2 = num_q[3*COEF_BITS-1:2*COEF_BITS];
  assign a1 = den_q[COEF_BITS-1:0];
  assign a2 = den_q[2*COEF_BITS-1:COEF_BITS];

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state_q)
      ST_ACC:  coef_op = b1;
      ST_A1:   coef_op = a1;
      ST_Z1:   coef_op = b2;
      ST_A2:   coef_op = a2;
      default: coef_op = b0;
    endcase
    sig_op = (state_q == ST_A1 || state_q == ST_A2) ? y_q : x_q;
  end

  assign mul_res = coef_op * sig_op;

  // b0*x + z1 with the rounding half added
  assign acc_d = ACC_W'(prod_q) + ACC_W'(z1_q) + HALF;

  // round to the signal format and saturate
  assign y_sh = acc_q >>> COEF_FRAC;
  assign y_hi = y_sh[ACC_W-1:SIG_BITS-1];
  always_comb begin
    if ((&y_hi) || !(|y_hi)) begin
      y_d = y_sh[SIG_BITS-1:0];
    end else if (y_sh[ACC_W-1]) begin
      y_d = SIG_MIN;
    end else begin
      y_d = SIG_MAX;
    end
  end

  // feedback term removed, saturated to the delay width
  assign z_diff = sum_q - ACC_W'(prod_q);
  assign z_hi   = z_diff[ACC_W-1:STATE_BITS-1];
  always_comb begin
    if ((&z_hi) || !(|z_hi)) begin
      z_d = z_diff[STATE_BITS-1:0];
    end else if (z_diff[ACC_W-1]) begin
      z_d = Z_MIN;
    end else begin
      z_d = Z_MAX;
    end
  end

  // sequencer, delay values and coefficients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      z1_q    <= '0;
      z2_q    <= '0;
      num_q   <= '0;
      den_q   <= '0;
    end else begin
      if (num_we_i) begin
        num_q <= cfg_data_i;
      end
      if (den_we_i) begin
        den_q <= cfg_data_i[2*COEF_BITS-1:0];
      end
      unique case (state_q)
        ST_IDLE: begin
          if (clear_i) begin
            z1_q <= '0;
            z2_q <= '0;
          end else if (link_i.valid) begin
            state_q <= ST_MB0;
          end
        end
        ST_MB0:  state_q <= ST_ACC;
        ST_ACC:  state_q <= ST_YOUT;
        ST_YOUT: state_q <= ST_A1;
        ST_A1:   state_q <= ST_Z1;
        ST_Z1: begin
          z1_q    <= z_d;
          state_q <= ST_A2;
        end
        ST_A2:   state_q <= ST_Z2;
        ST_Z2: begin
          z2_q    <= z_d;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_res;
    if (state_q == ST_IDLE && link_i.valid) begin
      x_q <= link_i.y;
    end
    if (state_q == ST_ACC) begin
      acc_q <= acc_d;
    end
    if (state_q == ST_YOUT) begin
      y_q   <= y_d;
      sum_q <= ACC_W'(prod_q) + ACC_W'(z2_q);
    end
    if (state_q == ST_A2) begin
      sum_q <= ACC_W'(prod_q);
    end
  end

  // section output goes to the neighbour as soon as it is rounded
  assign link_o.valid = (state_q == ST_A1);
  assign link_o.y     = y_q;
  assign busy_o       = (state_q != ST_IDLE);

endmodule

/* test/tb_three_section_biquad_cascade.sv */
`timescale 1ns / 100ps

module tb_three_section_biquad_cascade;
  import tsbq_pkg::*;

  localparam int SECTIONS    = SECTIONS_DEF;
  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int COEF_BITS   = COEF_BITS_DEF;
  localparam int STATE_BITS  = STATE_BITS_DEF;
  localparam int COEF_FRAC   = COEF_BITS - 2;
  localparam int NUM_REGS    = 2 * SECTIONS;
  localparam int NUM_COEFS   = 5 * SECTIONS;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam int SETTLE_CYCLES = 4 * SECTIONS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef int coef_set_t [NUM_COEFS];
  typedef logic [COEF_BITS-1:0] coef_word_t;
  typedef logic [3*COEF_BITS-1:0] cfg_word_t;

  // per section: b0, b1, b2, a1, a2 in Q2.18
  localparam coef_set_t DESIGNED_SET = '{
    249037, -498074, 249037, -498074, 237240,
    262144, -262144, 262144, -249037, 236585,
    5243, 10486, 5243, -419430, 178258
  };
  localparam coef_set_t UNITY_SET = '{
    262144, 0, 0, 0, 0,
    262144, 0, 0, 0, 0,
    262144, 0, 0, 0, 0
  };

  // bit-exact model of the cascade and the store of filtered samples still due
  class cascade_scoreboard;
    logic [3*COEF_BITS-1:0]     coef_reg [NUM_REGS];
    longint                     delay_val [NUM_REGS];
    logic signed [SIG_BITS-1:0] filtered_due [$];
    int                         failures;

    function new();
      foreach (coef_reg[i]) coef_reg[i] = '0;
      foreach (delay_val[i]) delay_val[i] = 0;
      failures = 0;
    endfunction

    function void note_config(int unsigned idx, logic [3*COEF_BITS-1:0] data);
      if (idx >= NUM_REGS) return;
      if (idx % 2) coef_reg[idx] = {{COEF_BITS{1'b0}}, data[2*COEF_BITS-1:0]};
      else coef_reg[idx] = data;
    endfunction

    function longint clamp(longint v, int w);
      longint lim;
      lim = longint'(1) << (w - 1);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint coef_at(int idx, int slot);
      logic signed [COEF_BITS-1:0] c;
      c = coef_reg[idx][slot*COEF_BITS +: COEF_BITS];
      return c;
    endfunction

    function logic signed [SIG_BITS-1:0] run_cascade(logic [SAMPLE_BITS-1:0] smp);
      longint x, acc, y;
      int     s;
      x = longint'(smp) * (longint'(1) << SIG_FRAC);
      x = clamp(x, SIG_BITS);
      for (s = 0; s < SECTIONS; s++) begin
        acc = coef_at(2*s, 0) * x + delay_val[2*s];
        y = clamp((acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC, SIG_BITS);
        delay_val[2*s] = clamp(coef_at(2*s, 1) * x - coef_at(2*s+1, 0) * y
                               + delay_val[2*s+1], STATE_BITS);
        delay_val[2*s+1] = clamp(coef_at(2*s, 2) * x - coef_at(2*s+1, 1) * y, STATE_BITS);
        x = y;
      end
      return x[SIG_BITS-1:0];
    endfunction

    function void note_input(logic cmd, logic [SAMPLE_BITS-1:0] smp);
      if (cmd == CMD_CLEAR) begin
        foreach (delay_val[i]) delay_val[i] = 0;
      end else begin
        filtered_due.push_back(run_cascade(smp));
      end
    endfunction

    function void check_result(logic signed [SIG_BITS-1:0] got);
      logic signed [SIG_BITS-1:0] want;
      if (filtered_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("filtered sample %0d arrived with none due", got);
        return;
      end
      want = filtered_due.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10) $display("filtered mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       command_i = CMD_FILTER;
  logic [SAMPLE_BITS-1:0]     sample_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [SIG_BITS-1:0] filtered_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]    cfg_index_i = '0;
  logic [3*COEF_BITS-1:0]     cfg_data_i = '0;

  cascade_scoreboard      sb;
  logic                   quiet = 1'b0;
  int                     hold_ticket = 0;
  int                     hold_seen = 0;
  int                     hold_left = 0;
  int                     stall_left = 0;
  int                     stall_pick;
  int                     cycle_count = 0;
  logic [SAMPLE_BITS-1:0] held_sample = '0;

  three_section_biquad_cascade dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(filtered_o);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 60) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (stall_pick < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // idle cycles before the next input transfer
  function automatic int gap_len();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic cmd, logic [SAMPLE_BITS-1:0] smp);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    sample_i   <= smp;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, smp);
  endtask

  // mostly filter commands: rail values, steps of a held value and noise
  task automatic random_items(int count);
    logic cmd;
    int   pick;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 99) < 5) ? CMD_CLEAR : CMD_FILTER;
      pick = $urandom_range(0, 99);
      if (pick < 10) held_sample = '1;
      else if (pick < 20) held_sample = '0;
      else if (pick >= 50) held_sample = SAMPLE_BITS'($urandom);
      send_item(cmd, held_sample);
    end
  endtask

  // stop offering and let every due sample and the last delay update finish
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(int unsigned idx, logic [3*COEF_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx[CFG_IDX_BITS-1:0];
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
  endtask

  // write all six registers plus one stray index; junk fills unused upper bits
  task automatic program_cascade(coef_set_t c, logic junk);
    logic [3*COEF_BITS-1:0] num, den;
    coef_word_t             upper;
    for (int s = 0; s < SECTIONS; s++) begin
      num = {coef_word_t'(c[5*s+2]), coef_word_t'(c[5*s+1]), coef_word_t'(c[5*s])};
      upper = junk ? coef_word_t'($urandom) : '0;
      den = {upper, coef_word_t'(c[5*s+4]), coef_word_t'(c[5*s+3])};
      cfg_write(2*s, num);
      cfg_write(2*s+1, den);
    end
    cfg_write($urandom_range(NUM_REGS, 2**CFG_IDX_BITS - 1),
              cfg_word_t'({$urandom, $urandom}));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic coef_set_t random_coefs();
    coef_set_t c;
    foreach (c[i]) c[i] = int'($urandom_range(0, 2**COEF_BITS - 1)) - 2**(COEF_BITS-1);
    return c;
  endfunction

  function automatic coef_set_t flat_coefs(int v);
    coef_set_t c;
    foreach (c[i]) c[i] = v;
    return c;
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coefficients still zero after reset: every sample filters to zero
    send_item(CMD_FILTER, '0);
    send_item(CMD_FILTER, '1);
    send_item(CMD_CLEAR, '1);
    send_item(CMD_FILTER, 12'h800);
    send_item(CMD_FILTER, 12'h7FF);
    random_items(40);
    wait_drained();

    // high-pass, notch, low-pass: step response, clears and alternating bits
    program_cascade(DESIGNED_SET, 1'b1);
    repeat (8) send_item(CMD_FILTER, '1);
    send_item(CMD_CLEAR, '1);
    repeat (4) send_item(CMD_FILTER, '0);
    send_item(CMD_FILTER, 12'hAAA);
    send_item(CMD_FILTER, 12'h555);
    send_item(CMD_CLEAR, '0);
    send_item(CMD_FILTER, 12'h001);
    send_item(CMD_FILTER, 12'hFFE);
    random_items(200);

    // result side holds off while samples keep coming, so the block backs up
    quiet <= 1'b1;
    hold_ticket <= hold_ticket + 1;
    random_items(25);
    quiet <= 1'b0;
    random_items(150);
    wait_drained();
    random_items(100);
    wait_drained();

    // unity sections, first without any idling
    program_cascade(UNITY_SET, 1'b0);
    quiet <= 1'b1;
    random_items(100);
    quiet <= 1'b0;
    random_items(60);
    wait_drained();

    // coefficient rails drive outputs and delay values into saturation
    program_cascade(flat_coefs(2**(COEF_BITS-1) - 1), 1'b1);
    random_items(150);
    wait_drained();
    program_cascade(flat_coefs(-(2**(COEF_BITS-1))), 1'b1);
    random_items(150);
    wait_drained();

    // arbitrary coefficient sets
    repeat (3) begin
      program_cascade(random_coefs(), 1'b1);
      random_items(120);
      wait_drained();
    end

    // back to the designed filter with a second hold-off
    program_cascade(DESIGNED_SET, 1'b0);
    random_items(50);
    quiet <= 1'b1;
    hold_ticket <= hold_ticket + 1;
    random_items(25);
    quiet <= 1'b0;
    random_items(75);
    wait_drained();

    if (sb.failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
